// ----- rtl/sawbc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sawbc_pkg: shared definitions for the set-associative write-back cache
// Sizes, address fields, metadata layout and the control and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sawbc_pkg;

   localparam int SETS       = 64;
   localparam int WAYS       = 4;
   localparam int MEM_BLOCKS = 4096;

   localparam int ADDR_W     = 18;
   localparam int DATA_W     = 32;
   localparam int LINE_WORDS = 4;
   localparam int WORD_W     = 2;
   localparam int WORD_LSB   = 4;
   localparam int BLOCK_LSB  = 6;
   localparam int BLOCK_W    = ADDR_W - BLOCK_LSB;
   localparam int SET_W      = $clog2(SETS);
   localparam int TAG_W      = BLOCK_W - SET_W;
   localparam int WAY_W      = $clog2(WAYS);
   localparam int MEM_IDX_W  = $clog2(MEM_BLOCKS);
   localparam int STAMP_W    = 32;
   localparam int STATUS_W   = 2;

   localparam logic [STATUS_W-1:0] LINE_INVALID  = 2'd0;
   localparam logic [STATUS_W-1:0] LINE_VALID    = 2'd1;
   localparam logic [STATUS_W-1:0] LINE_MODIFIED = 2'd3;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef logic [LINE_WORDS-1:0][DATA_W-1:0] line_type;

   typedef struct packed {
      logic [TAG_W-1:0]    tag;
      logic [STATUS_W-1:0] status;
      logic [STAMP_W-1:0]  stamp;
   } way_meta_type;

   typedef way_meta_type [WAYS-1:0] meta_row_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_HIT_READ,
      S_SCAN,
      S_VICTIM,
      S_WRITEBACK,
      S_REFILL,
      S_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic lookup;
      logic hit_read;
      logic scan;
      logic victim_read;
      logic writeback;
      logic refill;
      logic done;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic hit;
      logic is_write;
      logic scan_last;
      logic out_free;
   } ctrl_status_type;

   // Block number modulo MEM_BLOCKS, which is a power of two.
   function automatic logic [MEM_IDX_W-1:0] mem_index(input logic [BLOCK_W-1:0] blk);
      logic [BLOCK_W+MEM_IDX_W-1:0] wide;
      wide = {{MEM_IDX_W{1'b0}}, blk};
      return wide[MEM_IDX_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ----- rtl/sawbc_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sawbc_if: request and response channels of the cache
// Valid/ready channels; an item moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface sawbc_req_if
   import sawbc_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic                     command;
   logic [ADDR_W-1:0]        address;
   logic signed [DATA_W-1:0] write_data;

   modport source (output valid, output command, output address, output write_data,
                   input ready);
   modport sink (input valid, input command, input address, input write_data,
                 output ready);
endinterface

interface sawbc_rsp_if
   import sawbc_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] read_data;
   logic                     hit;
   logic                     wrote_back;

   modport source (output valid, output read_data, output hit, output wrote_back,
                   input ready);
   modport sink (input valid, input read_data, input hit, input wrote_back,
                 output ready);
endinterface
`default_nettype wire

// ----- rtl/sawbc_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sawbc_ctrl: cache sequencer
// Steps each item through lookup, victim search, write-back and refill, and
// runs the clearing pass over the backing memory after reset.
// ----------------------------------------------------------------------------
module sawbc_ctrl
   import sawbc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire ctrl_status_type status,
   output ctrl_cmd_type         cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
            if (!status.hit) begin
               state_in = S_SCAN;
            end else if (status.is_write) begin
               state_in = S_DONE;
            end else begin
               state_in = S_HIT_READ;
            end
         end
         S_HIT_READ: begin
            cmd.hit_read = 1'b1;
            state_in     = S_DONE;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = S_VICTIM;
            end
         end
         S_VICTIM: begin
            cmd.victim_read = 1'b1;
            state_in        = S_WRITEBACK;
         end
         S_WRITEBACK: begin
            cmd.writeback = 1'b1;
            state_in      = S_REFILL;
         end
         S_REFILL: begin
            cmd.refill = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.done = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/sawbc_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sawbc_dpath: cache datapath
// Metadata, line and backing memories, the access counter, the victim search
// and the response register.
// ----------------------------------------------------------------------------
module sawbc_dpath
   import sawbc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ctrl_cmd_type             cmd,
   output ctrl_status_type               status,
   input  wire logic                     req_command,
   input  wire logic [ADDR_W-1:0]        req_address,
   input  wire logic signed [DATA_W-1:0] req_write_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [DATA_W-1:0]      rsp_read_data,
   output logic                          rsp_hit,
   output logic                          rsp_wrote_back
);

   // Memories
   meta_row_type        meta_mem [SETS];
   line_type            line_mem [SETS][WAYS];
   line_type            back_mem [MEM_BLOCKS];

   meta_row_type        meta_rd_ff;
   logic                meta_rdv_ff;
   line_type            line_rd_ff;
   line_type            back_rd_ff;

   // Control registers
   logic [SETS-1:0]      row_valid_ff, row_valid_in;
   logic [MEM_IDX_W-1:0] clr_ff, clr_in;
   logic [STAMP_W-1:0]   clock_ff, clock_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Item registers
   logic                 write_ff, write_in;
   logic [SET_W-1:0]     set_ff, set_in;
   logic [TAG_W-1:0]     tag_ff, tag_in;
   logic [WORD_W-1:0]    word_ff, word_in;
   logic [DATA_W-1:0]    wdata_ff, wdata_in;
   logic [WAY_W-1:0]     idx_ff, idx_in;
   logic [WAY_W-1:0]     vway_ff, vway_in;
   logic [STAMP_W-1:0]   best_ff, best_in;
   logic [DATA_W-1:0]    res_data_ff, res_data_in;
   logic                 res_hit_ff, res_hit_in;
   logic                 res_wb_ff, res_wb_in;
   logic [DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic                 rsp_wb_ff, rsp_wb_in;

   // Combinational signals
   meta_row_type         meta_eff;
   meta_row_type         meta_wdata;
   logic                 meta_we;
   logic                 hit_any;
   logic [WAY_W-1:0]     hit_way;
   logic [STAMP_W-1:0]   stamp_next;
   logic                 victim_mod;
   logic [MEM_IDX_W-1:0] victim_blk;
   logic [MEM_IDX_W-1:0] req_blk;
   logic [WAY_W-1:0]     line_way;
   logic                 line_we;
   logic                 line_re;
   logic [LINE_WORDS-1:0] line_mask;
   line_type             line_wdata;
   logic                 back_we;
   logic [MEM_IDX_W-1:0] back_widx;
   line_type             back_wdata;
   logic                 out_free;

   // A set never written since reset reads as all invalid with zero stamps.
   assign meta_eff   = meta_rdv_ff ? meta_rd_ff : '0;
   assign stamp_next = (clock_ff == {STAMP_W{1'b1}}) ? clock_ff : clock_ff + 1'b1;
   assign victim_mod = (meta_eff[vway_ff].status == LINE_MODIFIED);
   assign victim_blk = mem_index({meta_eff[vway_ff].tag, set_ff});
   assign req_blk    = mem_index({tag_ff, set_ff});
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      hit_any = 1'b0;
      hit_way = '0;
      // Walk downwards so that the lowest matching way wins.
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (meta_eff[w].tag == tag_ff &&
             (meta_eff[w].status == LINE_VALID || meta_eff[w].status == LINE_MODIFIED)) begin
            hit_any = 1'b1;
            hit_way = WAY_W'(w);
         end
      end
   end

   assign status.clear_last = (clr_ff == MEM_IDX_W'(MEM_BLOCKS - 1));
   assign status.hit        = hit_any;
   assign status.is_write   = write_ff;
   assign status.scan_last  = (idx_ff == WAY_W'(WAYS - 1));
   assign status.out_free   = out_free;

   always_comb begin
      row_valid_in = row_valid_ff;
      clr_in       = clr_ff;
      clock_in     = clock_ff;
      rsp_valid_in = rsp_valid_ff;
      write_in     = write_ff;
      set_in       = set_ff;
      tag_in       = tag_ff;
      word_in      = word_ff;
      wdata_in     = wdata_ff;
      idx_in       = idx_ff;
      vway_in      = vway_ff;
      best_in      = best_ff;
      res_data_in  = res_data_ff;
      res_hit_in   = res_hit_ff;
      res_wb_in    = res_wb_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_wb_in    = rsp_wb_ff;

      meta_we    = 1'b0;
      meta_wdata = meta_eff;
      line_way   = cmd.lookup ? hit_way : vway_ff;
      line_we    = 1'b0;
      line_re    = 1'b0;
      line_mask  = '0;
      line_wdata = back_rd_ff;
      back_we    = 1'b0;
      back_widx  = victim_blk;
      back_wdata = line_rd_ff;

      if (cmd.clear) begin
         back_we    = 1'b1;
         back_widx  = clr_ff;
         back_wdata = '0;
         clr_in     = clr_ff + 1'b1;
      end

      if (cmd.accept) begin
         write_in = (req_command == CMD_WRITE);
         set_in   = req_address[BLOCK_LSB +: SET_W];
         tag_in   = req_address[BLOCK_LSB + SET_W +: TAG_W];
         word_in  = req_address[WORD_LSB +: WORD_W];
         wdata_in = req_write_data;
      end

      if (cmd.lookup) begin
         clock_in    = stamp_next;
         res_hit_in  = hit_any;
         res_wb_in   = 1'b0;
         res_data_in = '0;
         idx_in      = WAY_W'(1);
         vway_in     = '0;
         best_in     = meta_eff[0].stamp;
         if (hit_any) begin
            meta_we                   = 1'b1;
            meta_wdata[hit_way].stamp = stamp_next;
            if (write_ff) begin
               meta_wdata[hit_way].status = LINE_MODIFIED;
               line_we                    = 1'b1;
               line_mask[word_ff]         = 1'b1;
               line_wdata[word_ff]        = wdata_ff;
            end else begin
               line_re = 1'b1;
            end
         end
      end

      if (cmd.hit_read) begin
         res_data_in = line_rd_ff[word_ff];
      end

      if (cmd.scan) begin
         // Strictly smaller only, so ties stay with the lower way.
         if (meta_eff[idx_ff].stamp < best_ff) begin
            best_in = meta_eff[idx_ff].stamp;
            vway_in = idx_ff;
         end
         idx_in = idx_ff + 1'b1;
      end

      if (cmd.victim_read) begin
         line_re = 1'b1;
      end

      if (cmd.writeback) begin
         back_we   = victim_mod;
         res_wb_in = victim_mod;
      end

      if (cmd.refill) begin
         line_we                   = 1'b1;
         line_mask                 = '1;
         meta_we                   = 1'b1;
         meta_wdata[vway_ff].tag   = tag_ff;
         meta_wdata[vway_ff].stamp = clock_ff;
         if (write_ff) begin
            line_wdata[word_ff]        = wdata_ff;
            meta_wdata[vway_ff].status = LINE_MODIFIED;
            res_data_in                = '0;
         end else begin
            meta_wdata[vway_ff].status = LINE_VALID;
            res_data_in                = back_rd_ff[word_ff];
         end
      end

      if (meta_we) begin
         row_valid_in[set_ff] = 1'b1;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data_ff;
         rsp_hit_in   = res_hit_ff;
         rsp_wb_in    = res_wb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         clr_ff       <= '0;
         clock_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         clr_ff       <= clr_in;
         clock_ff     <= clock_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      write_ff    <= write_in;
      set_ff      <= set_in;
      tag_ff      <= tag_in;
      word_ff     <= word_in;
      wdata_ff    <= wdata_in;
      idx_ff      <= idx_in;
      vway_ff     <= vway_in;
      best_ff     <= best_in;
      res_data_ff <= res_data_in;
      res_hit_ff  <= res_hit_in;
      res_wb_ff   <= res_wb_in;
      rsp_data_ff <= rsp_data_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_wb_ff   <= rsp_wb_in;
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[set_ff] <= meta_wdata;
      end
      if (cmd.accept) begin
         meta_rd_ff  <= meta_mem[req_address[BLOCK_LSB +: SET_W]];
         meta_rdv_ff <= row_valid_ff[req_address[BLOCK_LSB +: SET_W]];
      end
   end

   always_ff @(posedge clock) begin
      if (line_we) begin
         for (int w = 0; w < LINE_WORDS; w++) begin
            if (line_mask[w]) begin
               line_mem[set_ff][line_way][w] <= line_wdata[w];
            end
         end
      end
      if (line_re) begin
         line_rd_ff <= line_mem[set_ff][line_way];
      end
   end

   // The victim block never equals the requested block when it is written
   // back, since a modified line with the requested tag would have hit.
   always_ff @(posedge clock) begin
      if (back_we) begin
         back_mem[back_widx] <= back_wdata;
      end
      if (cmd.writeback) begin
         back_rd_ff <= back_mem[req_blk];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_wrote_back = rsp_wb_ff;

endmodule
`default_nettype wire

// ----- rtl/set_assoc_writeback_cache.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache: four-way set-associative write-back cache
// Write-allocate data cache with its backing memory held inside.
//
//   Channel   Direction  Contents
//   req_ch    in         command, address, write_data
//   rsp_ch    out        read_data, hit, wrote_back
//
// A write hit runs lookup, done; a read hit adds hit read; a miss runs lookup,
// victim search, victim read, write-back, refill, done. The sequencer runs one
// item at a time; the search visits one way per cycle. After reset a clearing
// pass zeroes all MEM_BLOCKS (4096) backing lines, one a cycle, with req_ch
// not ready. The response register lets the next item be taken while a result
// waits; a stalled rsp_ch holds the following item at its final step.
// ----------------------------------------------------------------------------
module set_assoc_writeback_cache
   import sawbc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   sawbc_req_if.sink    req_ch,
   sawbc_rsp_if.source  rsp_ch
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   sawbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sawbc_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_command    (req_ch.command),
      .req_address    (req_ch.address),
      .req_write_data (req_ch.write_data),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_read_data  (rsp_ch.read_data),
      .rsp_hit        (rsp_ch.hit),
      .rsp_wrote_back (rsp_ch.wrote_back)
   );

endmodule
`default_nettype wire

// ----- tb/set_assoc_writeback_cache_tb.sv -----
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache_tb: self-checking bench for the write-back cache
// A driver feeds read and write items from a queue. Each accepted item is
// run through a behavioural copy of the cache and its backing memory, and
// the monitor compares every response with the oldest prediction. Both
// channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module set_assoc_writeback_cache_tb
   import sawbc_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int TAIL_CYCLES    = 40;
   localparam int RANDOM_ITEMS   = 1000;
   localparam int QUIET_ITEMS    = 120;

   typedef struct {
      logic               command;
      logic [ADDR_W-1:0]  address;
      logic [DATA_W-1:0]  write_data;
      bit                 wait_drain;
   } access_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_data;
      logic                     hit;
      logic                     wrote_back;
   } cache_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sawbc_req_if req_ch ();
   sawbc_rsp_if rsp_ch ();

   set_assoc_writeback_cache uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #4 clock = ~clock;

   // Shadow copy of the cache contents and the memory behind it.
   logic [TAG_W-1:0]    tag_mirror    [SETS*WAYS];
   logic [STATUS_W-1:0] status_mirror [SETS*WAYS];
   logic [STAMP_W-1:0]  stamp_mirror  [SETS*WAYS];
   logic [DATA_W-1:0]   word_mirror   [SETS*WAYS*LINE_WORDS];
   logic [DATA_W-1:0]   mem_mirror    [MEM_BLOCKS*LINE_WORDS];
   logic [STAMP_W-1:0]  access_count;

   access_item_type pending_accesses [$];
   cache_rsp_type   awaited_rsp [$];

   int unsigned n_sent;
   int unsigned n_done;
   int          errors = 0;
   int          req_gap;
   int          rsp_stall;
   int          idle_cycles;
   bit          quiet;

   // The shadow copy starts from the same state as the cache after reset.
   function automatic void clear_mirror();
      access_count = '0;
      for (int i = 0; i < SETS*WAYS; i++) begin
         tag_mirror[i]    = '0;
         status_mirror[i] = LINE_INVALID;
         stamp_mirror[i]  = '0;
      end
      for (int i = 0; i < SETS*WAYS*LINE_WORDS; i++) word_mirror[i] = '0;
      for (int i = 0; i < MEM_BLOCKS*LINE_WORDS; i++) mem_mirror[i] = '0;
   endfunction

   function automatic cache_rsp_type cache_access(input logic cmd,
                                                  input logic [ADDR_W-1:0] addr,
                                                  input logic [DATA_W-1:0] wdata);
      logic [BLOCK_W-1:0] blk;
      logic [SET_W-1:0]   set_idx;
      logic [TAG_W-1:0]   tag;
      logic [WORD_W-1:0]  word;
      logic [STAMP_W-1:0] stamp;
      logic [STAMP_W-1:0] oldest;
      int unsigned        base;
      int unsigned        slot;
      int unsigned        mblk;
      int unsigned        vblk;
      int                 way;
      bit                 found;
      cache_rsp_type      r;
      blk     = addr[ADDR_W-1:BLOCK_LSB];
      set_idx = blk[SET_W-1:0];
      tag     = blk[BLOCK_W-1:SET_W];
      word    = addr[WORD_LSB +: WORD_W];
      base    = set_idx * WAYS;
      if (access_count != '1) access_count++;
      stamp = access_count;
      r     = '0;
      found = 1'b0;
      way   = 0;
      for (int w = 0; w < WAYS; w++) begin
         if (!found && tag_mirror[base+w] == tag &&
             (status_mirror[base+w] == LINE_VALID ||
              status_mirror[base+w] == LINE_MODIFIED)) begin
            way   = w;
            found = 1'b1;
         end
      end
      if (found) begin
         r.hit = 1'b1;
      end else begin
         // Oldest stamp is the victim; equal stamps favour the lowest way.
         oldest = stamp_mirror[base];
         for (int w = 1; w < WAYS; w++) begin
            if (stamp_mirror[base+w] < oldest) begin
               oldest = stamp_mirror[base+w];
               way    = w;
            end
         end
         slot = base + way;
         if (status_mirror[slot] == LINE_MODIFIED) begin
            vblk = (tag_mirror[slot] * SETS + set_idx) % MEM_BLOCKS;
            for (int i = 0; i < LINE_WORDS; i++)
               mem_mirror[vblk*LINE_WORDS+i] = word_mirror[slot*LINE_WORDS+i];
            r.wrote_back = 1'b1;
         end
         mblk = blk % MEM_BLOCKS;
         for (int i = 0; i < LINE_WORDS; i++)
            word_mirror[slot*LINE_WORDS+i] = mem_mirror[mblk*LINE_WORDS+i];
         tag_mirror[slot]    = tag;
         status_mirror[slot] = LINE_VALID;
      end
      slot = base + way;
      stamp_mirror[slot] = stamp;
      if (cmd == CMD_WRITE) begin
         word_mirror[slot*LINE_WORDS+word] = wdata;
         status_mirror[slot] = LINE_MODIFIED;
      end else begin
         r.read_data = word_mirror[slot*LINE_WORDS+word];
      end
      return r;
   endfunction

   task automatic add_access(input logic cmd, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] wdata, input bit drain);
      access_item_type it;
      it.command    = cmd;
      it.address    = addr;
      it.write_data = wdata;
      it.wait_drain = drain;
      pending_accesses.push_back(it);
   endtask

   // Driver: presents queued items, with random idle bursts between them.
   always @(posedge clock) begin : driver
      access_item_type nxt;
      bit              take;
      if (reset) begin
         req_ch.valid      <= 1'b0;
         req_ch.command    <= CMD_READ;
         req_ch.address    <= '0;
         req_ch.write_data <= '0;
         req_gap           <= 0;
         n_sent            <= 0;
         quiet             <= 1'b0;
         clear_mirror();
      end else begin
         take = req_ch.valid && req_ch.ready;
         quiet <= (pending_accesses.size() < QUIET_ITEMS);
         if (take) begin
            awaited_rsp.push_back(cache_access(req_ch.command, req_ch.address,
                                               req_ch.write_data));
            n_sent <= n_sent + 1;
         end
         if (take || !req_ch.valid) begin
            if (req_gap != 0) begin
               req_gap      <= req_gap - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_accesses.size() == 0 ||
                         (pending_accesses[0].wait_drain &&
                          (take || n_sent != n_done))) begin
               req_ch.valid <= 1'b0;
            end else begin
               nxt = pending_accesses.pop_front();
               req_ch.valid      <= 1'b1;
               req_ch.command    <= nxt.command;
               req_ch.address    <= nxt.address;
               req_ch.write_data <= nxt.write_data;
               if (!quiet && $urandom_range(0, 7) == 0)
                  req_gap <= $urandom_range(1, 17);
            end
         end
      end
   end

   // Monitor: takes responses, stalls at random and checks each field.
   always @(posedge clock) begin : monitor
      cache_rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall    <= 0;
         n_done       <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            n_done <= n_done + 1;
            if (awaited_rsp.size() == 0) begin
               $display("%0t: response with none outstanding: read_data %h hit %b wrote_back %b",
                        $time, rsp_ch.read_data, rsp_ch.hit, rsp_ch.wrote_back);
               errors++;
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_ch.read_data !== want.read_data) begin
                  $display("%0t: read_data expected %h actual %h",
                           $time, want.read_data, rsp_ch.read_data);
                  errors++;
               end
               if (rsp_ch.hit !== want.hit) begin
                  $display("%0t: hit expected %b actual %b", $time, want.hit, rsp_ch.hit);
                  errors++;
               end
               if (rsp_ch.wrote_back !== want.wrote_back) begin
                  $display("%0t: wrote_back expected %b actual %b",
                           $time, want.wrote_back, rsp_ch.wrote_back);
                  errors++;
               end
            end
         end
         if (rsp_stall != 0) begin
            rsp_stall    <= rsp_stall - 1;
            rsp_ch.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_stall    <= $urandom_range(0, 16);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // The clearing pass after reset shows no handshakes, so the limit is wide.
   always @(posedge clock) begin : watchdog
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [TAG_W-1:0]  tag;
      logic [SET_W-1:0]  set_idx;
      logic [WORD_W-1:0] word;
      logic [3:0]        low;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
      int                hot;

      // Directed part. Set 0 is filled with tags 0 to 3, all stamps tying at
      // first, then tags 4 and 0 push out modified lines.
      add_access(CMD_READ,  18'h00000, 32'h0,        1'b0);
      add_access(CMD_WRITE, 18'h00010, 32'h7FFFFFFF, 1'b0);
      add_access(CMD_READ,  18'h00010, 32'h0,        1'b0);
      add_access(CMD_WRITE, 18'h01020, 32'h80000000, 1'b0);
      add_access(CMD_WRITE, 18'h02030, 32'hFFFFFFFF, 1'b0);
      add_access(CMD_READ,  18'h03000, 32'h12345678, 1'b0);
      add_access(CMD_READ,  18'h04000, 32'h0,        1'b0);
      add_access(CMD_READ,  18'h00010, 32'h0,        1'b0);
      add_access(CMD_WRITE, 18'h3FFFF, 32'hFFFFFFFF, 1'b0);
      add_access(CMD_READ,  18'h3FFF0, 32'h0,        1'b0);
      add_access(CMD_WRITE, 18'h3FFFF, 32'h00000000, 1'b0);
      add_access(CMD_READ,  18'h01020, 32'h0,        1'b1);
      add_access(CMD_READ,  18'h0000F, 32'hFFFFFFFF, 1'b0);
      add_access(CMD_WRITE, 18'h05030, 32'h55555555, 1'b0);
      add_access(CMD_WRITE, 18'h06020, 32'hAAAAAAAA, 1'b0);
      add_access(CMD_READ,  18'h02030, 32'h0,        1'b0);
      add_access(CMD_READ,  18'h3F03F, 32'h0,        1'b0);

      // Random part: mostly a few busy sets with more tags than ways, so hits,
      // clean evictions and write-backs all occur; the rest spans every address.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(0, 99) < 85) begin
            hot     = $urandom_range(0, 3);
            set_idx = SET_W'((hot < 2) ? hot : SETS - 4 + hot);
            tag     = TAG_W'($urandom_range(0, 6));
            word    = WORD_W'($urandom_range(0, 3));
            low     = 4'($urandom_range(0, 15));
            addr    = {tag, set_idx, word, low};
         end else begin
            addr = ADDR_W'($urandom);
         end
         if ($urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 3))
               0: data = 32'h00000000;
               1: data = 32'h7FFFFFFF;
               2: data = 32'h80000000;
               default: data = 32'hFFFFFFFF;
            endcase
         end else begin
            data = $urandom;
         end
         add_access(1'($urandom_range(0, 1)), addr, data, (n == 300 || n == 700));
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_accesses.size() != 0 || req_ch.valid || awaited_rsp.size() != 0);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (awaited_rsp.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, awaited_rsp.size());
      end
      if (errors == 0 && awaited_rsp.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/sawbc_pkg.sv
rtl/sawbc_if.sv
rtl/sawbc_ctrl.sv
rtl/sawbc_dpath.sv
rtl/set_assoc_writeback_cache.sv
tb/set_assoc_writeback_cache_tb.sv
